/* sv/hs_pkg.sv */
// Shared types, codes and defaults for the heap sorter.
`default_nettype none

package hs_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int VALUE_W        = 32;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_BUILD_RD,
      ST_BUILD_NODE,
      ST_SIFT_L,
      ST_SIFT_R,
      ST_SIFT_CMP,
      ST_NEXT,
      ST_EXT_RD0,
      ST_EXT_RDI,
      ST_EXT_SWAP,
      ST_EMIT_RD,
      ST_EMIT_LD
   } hs_state_type;

   typedef enum logic [1:0] {
      RA_INDEX,
      RA_LEFT,
      RA_RIGHT,
      RA_ROOT
   } hs_raddr_type;

   typedef enum logic [1:0] {
      WA_COUNT,
      WA_HOLE,
      WA_INDEX
   } hs_waddr_type;

   typedef enum logic [1:0] {
      WD_INPUT,
      WD_CHILD,
      WD_NODE,
      WD_ROOT
   } hs_wdata_type;

   typedef enum logic [2:0] {
      I_HOLD,
      I_DEC,
      I_INC,
      I_TOP,
      I_ZERO
   } hs_iop_type;

   typedef struct packed {
      logic         load;
      logic         mem_we;
      hs_waddr_type waddr_sel;
      hs_wdata_type wdata_sel;
      hs_raddr_type raddr_sel;
      logic         node_ld;
      logic         swap_ld;
      logic         left_ld;
      logic         step;
      hs_iop_type   i_op;
      logic         emit_ld;
   } hs_cmd_type;

   typedef struct packed {
      logic load_end;
      logic single;
      logic left_ok;
      logic take;
      logic i_zero;
      logic i_one;
      logic emit_last;
      logic out_busy;
   } hs_sts_type;

endpackage

`default_nettype wire

/* sv/hs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* sv/hs_dp.sv */
// Heap sorter datapath: heap store, index registers, sift compare and output register.
`default_nettype none

module hs_dp #(
   parameter int CAPACITY   = hs_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = hs_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire hs_pkg::hs_cmd_type          cmd,
   output hs_pkg::hs_sts_type               sts,
   input  wire logic [hs_pkg::VALUE_W-1:0]  in_value,
   input  wire logic                        in_last,
   output logic      [hs_pkg::VALUE_W-1:0]  out_value,
   output logic                             out_last,
   output logic                             out_valid,
   input  wire logic                        out_ready
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CH_W  = IDX_W + 2;

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      size_ff, size_in;
   logic [IDX_W-1:0]      i_ff, i_in;
   logic [IDX_W-1:0]      hole_ff, hole_in;
   logic [DATA_WIDTH-1:0] nv_ff, nv_in;
   logic [DATA_WIDTH-1:0] lv_ff, lv_in;
   logic [DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_valid_ff, out_valid_in;

   logic signed [hs_pkg::VALUE_W-1:0] in_signed;
   logic signed [DATA_WIDTH-1:0]      in_ext;
   logic signed [DATA_WIDTH-1:0]      out_signed;

   logic [CH_W-1:0]       left_w, right_w;
   logic [IDX_W-1:0]      left_a, right_a;
   logic                  right_ok;
   logic                  right_big;
   logic [DATA_WIDTH-1:0] child_v;
   logic [IDX_W-1:0]      child_a;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

   hs_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Sign-extend or truncate between the 32-bit port and the stored width.
   assign in_signed  = $signed(in_value);
   assign in_ext     = DATA_WIDTH'(in_signed);
   assign out_signed = $signed(out_data_ff);
   assign out_value  = hs_pkg::VALUE_W'(out_signed);
   assign out_last   = out_last_ff;
   assign out_valid  = out_valid_ff;

   assign left_w  = CH_W'({hole_ff, 1'b0}) + CH_W'(1);
   assign right_w = CH_W'({hole_ff, 1'b0}) + CH_W'(2);
   assign left_a  = left_w[IDX_W-1:0];
   assign right_a = right_w[IDX_W-1:0];
   assign right_ok = right_w < CH_W'(size_ff);

   // The right child wins only when strictly larger, as does the move down.
   assign right_big = right_ok && ($signed(mem_rdata) > $signed(lv_ff));
   assign child_v   = right_big ? mem_rdata : lv_ff;
   assign child_a   = right_big ? right_a : left_a;

   always_comb begin
      sts.load_end  = in_last || (cnt_ff == CNT_W'(CAPACITY - 1));
      sts.single    = (cnt_ff == '0);
      sts.left_ok   = left_w < CH_W'(size_ff);
      sts.take      = $signed(child_v) > $signed(nv_ff);
      sts.i_zero    = (i_ff == '0);
      sts.i_one     = (i_ff == IDX_W'(1));
      sts.emit_last = ((CNT_W'(i_ff) + CNT_W'(1)) == n_ff);
      sts.out_busy  = out_valid_ff && !out_ready;
   end

   always_comb begin
      mem_we = cmd.mem_we;
      case (cmd.waddr_sel)
         hs_pkg::WA_COUNT: mem_waddr = cnt_ff[IDX_W-1:0];
         hs_pkg::WA_HOLE:  mem_waddr = hole_ff;
         hs_pkg::WA_INDEX: mem_waddr = i_ff;
         default:          mem_waddr = hole_ff;
      endcase
      case (cmd.wdata_sel)
         hs_pkg::WD_INPUT: mem_wdata = in_ext;
         hs_pkg::WD_CHILD: mem_wdata = child_v;
         hs_pkg::WD_NODE:  mem_wdata = nv_ff;
         hs_pkg::WD_ROOT:  mem_wdata = lv_ff;
         default:          mem_wdata = nv_ff;
      endcase
      case (cmd.raddr_sel)
         hs_pkg::RA_INDEX: mem_raddr = i_ff;
         hs_pkg::RA_LEFT:  mem_raddr = left_a;
         hs_pkg::RA_RIGHT: mem_raddr = right_a;
         hs_pkg::RA_ROOT:  mem_raddr = '0;
         default:          mem_raddr = '0;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      size_in      = size_ff;
      i_in         = i_ff;
      hole_in      = hole_ff;
      nv_in        = nv_ff;
      lv_in        = lv_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !out_ready;

      if (cmd.load) begin
         if (sts.load_end) begin
            cnt_in = '0;
            n_in   = cnt_ff + CNT_W'(1);
            // First parent of the heap is (n - 2) / 2, which is (count - 1) / 2.
            i_in   = sts.single ? '0 : IDX_W'((cnt_ff - CNT_W'(1)) >> 1);
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end

      if (cmd.node_ld) begin
         nv_in   = mem_rdata;
         hole_in = i_ff;
         size_in = n_ff;
      end
      if (cmd.swap_ld) begin
         nv_in   = mem_rdata;
         hole_in = '0;
         size_in = CNT_W'(i_ff);
      end
      if (cmd.left_ld) begin
         lv_in = mem_rdata;
      end
      if (cmd.step && sts.take) begin
         hole_in = child_a;
      end

      case (cmd.i_op)
         hs_pkg::I_HOLD: i_in = i_in;
         hs_pkg::I_DEC:  i_in = i_ff - IDX_W'(1);
         hs_pkg::I_INC:  i_in = i_ff + IDX_W'(1);
         hs_pkg::I_TOP:  i_in = IDX_W'(n_ff - CNT_W'(1));
         hs_pkg::I_ZERO: i_in = '0;
         default:        i_in = i_in;
      endcase

      if (cmd.emit_ld) begin
         out_data_in  = mem_rdata;
         out_last_in  = sts.emit_last;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff        <= n_in;
      size_ff     <= size_in;
      i_ff        <= i_in;
      hole_ff     <= hole_in;
      nv_ff       <= nv_in;
      lv_ff       <= lv_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

/* sv/hs_ctrl.sv */
// Heap sorter controller: sequences load, heap build, extraction and output.
`default_nettype none

module hs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire hs_pkg::hs_sts_type sts,
   output hs_pkg::hs_cmd_type      cmd
);

   hs_pkg::hs_state_type state_ff, state_in;
   logic                 build_ff, build_in;

   always_comb begin
      state_in = state_ff;
      build_in = build_ff;
      case (state_ff)
         hs_pkg::ST_LOAD: begin
            if (in_valid && sts.load_end) begin
               if (sts.single) begin
                  state_in = hs_pkg::ST_EMIT_RD;
               end else begin
                  state_in = hs_pkg::ST_BUILD_RD;
                  build_in = 1'b1;
               end
            end
         end
         hs_pkg::ST_BUILD_RD:   state_in = hs_pkg::ST_BUILD_NODE;
         hs_pkg::ST_BUILD_NODE: state_in = hs_pkg::ST_SIFT_L;
         hs_pkg::ST_SIFT_L: begin
            state_in = sts.left_ok ? hs_pkg::ST_SIFT_R : hs_pkg::ST_NEXT;
         end
         hs_pkg::ST_SIFT_R: state_in = hs_pkg::ST_SIFT_CMP;
         hs_pkg::ST_SIFT_CMP: begin
            state_in = sts.take ? hs_pkg::ST_SIFT_L : hs_pkg::ST_NEXT;
         end
         hs_pkg::ST_NEXT: begin
            if (build_ff) begin
               if (sts.i_zero) begin
                  build_in = 1'b0;
                  state_in = hs_pkg::ST_EXT_RD0;
               end else begin
                  state_in = hs_pkg::ST_BUILD_RD;
               end
            end else begin
               state_in = sts.i_one ? hs_pkg::ST_EMIT_RD : hs_pkg::ST_EXT_RD0;
            end
         end
         hs_pkg::ST_EXT_RD0:  state_in = hs_pkg::ST_EXT_RDI;
         hs_pkg::ST_EXT_RDI:  state_in = hs_pkg::ST_EXT_SWAP;
         hs_pkg::ST_EXT_SWAP: state_in = hs_pkg::ST_SIFT_L;
         hs_pkg::ST_EMIT_RD: begin
            if (!sts.out_busy) begin
               state_in = hs_pkg::ST_EMIT_LD;
            end
         end
         hs_pkg::ST_EMIT_LD: begin
            state_in = sts.emit_last ? hs_pkg::ST_LOAD : hs_pkg::ST_EMIT_RD;
         end
         default: state_in = hs_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      in_ready      = 1'b0;
      cmd.load      = 1'b0;
      cmd.mem_we    = 1'b0;
      cmd.waddr_sel = hs_pkg::WA_HOLE;
      cmd.wdata_sel = hs_pkg::WD_NODE;
      cmd.raddr_sel = hs_pkg::RA_INDEX;
      cmd.node_ld   = 1'b0;
      cmd.swap_ld   = 1'b0;
      cmd.left_ld   = 1'b0;
      cmd.step      = 1'b0;
      cmd.i_op      = hs_pkg::I_HOLD;
      cmd.emit_ld   = 1'b0;
      case (state_ff)
         hs_pkg::ST_LOAD: begin
            in_ready      = 1'b1;
            cmd.load      = in_valid;
            cmd.mem_we    = in_valid;
            cmd.waddr_sel = hs_pkg::WA_COUNT;
            cmd.wdata_sel = hs_pkg::WD_INPUT;
         end
         hs_pkg::ST_BUILD_RD: begin
            cmd.raddr_sel = hs_pkg::RA_INDEX;
         end
         hs_pkg::ST_BUILD_NODE: begin
            cmd.node_ld = 1'b1;
         end
         hs_pkg::ST_SIFT_L: begin
            cmd.raddr_sel = hs_pkg::RA_LEFT;
            // A leaf: the carried value settles into the hole.
            if (!sts.left_ok) begin
               cmd.mem_we    = 1'b1;
               cmd.waddr_sel = hs_pkg::WA_HOLE;
               cmd.wdata_sel = hs_pkg::WD_NODE;
            end
         end
         hs_pkg::ST_SIFT_R: begin
            cmd.left_ld   = 1'b1;
            cmd.raddr_sel = hs_pkg::RA_RIGHT;
         end
         hs_pkg::ST_SIFT_CMP: begin
            cmd.mem_we    = 1'b1;
            cmd.waddr_sel = hs_pkg::WA_HOLE;
            cmd.wdata_sel = sts.take ? hs_pkg::WD_CHILD : hs_pkg::WD_NODE;
            cmd.step      = 1'b1;
         end
         hs_pkg::ST_NEXT: begin
            if (build_ff) begin
               cmd.i_op = sts.i_zero ? hs_pkg::I_TOP : hs_pkg::I_DEC;
            end else begin
               cmd.i_op = sts.i_one ? hs_pkg::I_ZERO : hs_pkg::I_DEC;
            end
         end
         hs_pkg::ST_EXT_RD0: begin
            cmd.raddr_sel = hs_pkg::RA_ROOT;
         end
         hs_pkg::ST_EXT_RDI: begin
            cmd.left_ld   = 1'b1;
            cmd.raddr_sel = hs_pkg::RA_INDEX;
         end
         hs_pkg::ST_EXT_SWAP: begin
            // The old root goes to the end of the heap; the last entry becomes the hole value.
            cmd.mem_we    = 1'b1;
            cmd.waddr_sel = hs_pkg::WA_INDEX;
            cmd.wdata_sel = hs_pkg::WD_ROOT;
            cmd.swap_ld   = 1'b1;
         end
         hs_pkg::ST_EMIT_RD: begin
            cmd.raddr_sel = hs_pkg::RA_INDEX;
         end
         hs_pkg::ST_EMIT_LD: begin
            cmd.emit_ld = 1'b1;
            cmd.i_op    = hs_pkg::I_INC;
         end
         default: begin
            cmd.i_op = hs_pkg::I_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hs_pkg::ST_LOAD;
         build_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         build_ff <= build_in;
      end
   end

endmodule

`default_nettype wire

/* sv/heap_sorter.sv */
// Heap sorter top level: a set of signed words in, the same words out in ascending order.
//
// The req channel takes one value per word; req_tlast marks the final word of
// a set, and a word that fills the store (CAPACITY words) also ends the set.
// Loading accepts one word per cycle. After the final word the block builds a
// max-heap in its store, which has one write and one read port, and then
// moves the root to the end n-1 times. Each sift level reads the left child,
// reads the right child, then compares and writes, so sorting speed is
// bounded by the one read port of the store.
// The sorted words then leave on the rsp channel, each loaded into the output
// register once the previous word is taken, with rsp_tlast on the largest. rsp
// holds its word while the receiver stalls. req_tready is high only during
// loading, which starts again as soon as the final sorted word sits in the output register.
// Reset empties the set and the output register; store contents are left as
// they are and are never read before being loaded.
`default_nettype none

module heap_sorter #(
   parameter int CAPACITY   = hs_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = hs_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [hs_pkg::VALUE_W-1:0] req_tdata,  // [31:0] value
   input  wire logic                       req_tlast,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [hs_pkg::VALUE_W-1:0] rsp_tdata,  // [31:0] sorted_value
   output logic                            rsp_tlast
);

   hs_pkg::hs_cmd_type cmd;
   hs_pkg::hs_sts_type sts;

   hs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   hs_dp #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_value  (req_tdata),
      .in_last   (req_tlast),
      .out_value (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready)
   );

endmodule

`default_nettype wire
